// ----- sv/pte_pkg.sv -----
`default_nettype none
package pte_pkg;
	localparam int TableDepth = 16;
	localparam int LifeBits = 16;
	localparam int IdW = 60;
	localparam int KindW = 3;
	localparam int TxnW = 32;
	localparam int LifeInW = 16;
	localparam int CountW = 5;

	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_PAGE = 2'd2;
	localparam logic [1:0] REQ_TICK = 2'd3;

	localparam logic [1:0] RES_ADD = 2'd0;
	localparam logic [1:0] RES_REMOVE = 2'd1;
	localparam logic [1:0] RES_PAGE = 2'd2;
	localparam logic [1:0] RES_SUMMARY = 2'd3;
endpackage
`default_nettype wire

// ----- sv/pte_mem.sv -----
`default_nettype none
module pte_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/paging_table_with_expiry.sv -----
// channel | signals                                                  | handshake
// request | req_type mobile_id chan_kind txn_number lifetime         | start, busy
// result  | result_kind first_id first_kind second_id second_kind    | strobe
//         | has_second found_txn entry_count was_renewed table_full  |
//         | last_result                                              |
// one item at a time; the table sits in one memory with a registered read port, and
// each request walks the n used entries once while busy.
// page all purges expired entries in that walk, then reads the m survivors back in
// pairs, a lone last one on its own, and then gives the summary.
// reset clears only the entry count and control; no clearing pass.
// results go out with strobe, each page message twice in a row; a tick gives none; the receiver cannot stall.
`default_nettype none
module paging_table_with_expiry #(
	parameter int TABLE_DEPTH = pte_pkg::TableDepth,
	parameter int LIFE_BITS = pte_pkg::LifeBits
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [59:0] mobile_id,
	input  wire logic [2:0]  chan_kind,
	input  wire logic [31:0] txn_number,
	input  wire logic [15:0] lifetime,
	output logic             strobe,
	output logic [1:0]       result_kind,
	output logic [59:0]      first_id,
	output logic [2:0]       first_kind,
	output logic [59:0]      second_id,
	output logic [2:0]       second_kind,
	output logic             has_second,
	output logic [31:0]      found_txn,
	output logic [4:0]       entry_count,
	output logic             was_renewed,
	output logic             table_full,
	output logic             last_result
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = 60 + 3 + 32 + LIFE_BITS;
	localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DONE = 3'd2;
	localparam logic [2:0] ST_PAGE = 3'd3;
	localparam logic [2:0] ST_SUM = 3'd4;

	localparam logic [1:0] REQ_ADD_C = pte_pkg::REQ_ADD;
	localparam logic [1:0] REQ_REM_C = pte_pkg::REQ_REMOVE;
	localparam logic [1:0] REQ_TICK_C = pte_pkg::REQ_TICK;

	typedef struct packed {
		logic [59:0]          id;
		logic [2:0]           kind;
		logic [31:0]          txn;
		logic [LIFE_BITS-1:0] life;
	} entry_t;

	logic [2:0]    state_q;
	logic [CW-1:0] used_q, rd_q, wr_q;
	logic          rv_q;
	logic [1:0]    req_q;
	logic [59:0]   id_q;
	logic [2:0]    kind_q;
	logic [31:0]   txn_q;
	logic [LIFE_BITS-1:0] life_q;
	logic          found_q;
	logic [31:0]   ftxn_q;
	logic          half_q, rep_q;
	entry_t        first_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;

	pte_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign busy = (state_q != ST_IDLE);
	assign raddr = rd_q[AW-1:0];

	// scan step: rdata holds the entry read last cycle, written back compacted at wr_q
	logic hit, keep;
	always_comb begin
		hit = rv_q && (rdata.id == id_q) && !found_q;
		keep = 1'b1;
		we = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = rdata;
		if (state_q == ST_SCAN && rv_q) begin
			case (req_q)
				REQ_ADD_C: begin
					if (hit) begin
						we = 1'b1;
						wdata.life = life_q;
					end
				end
				REQ_REM_C: begin
					keep = !hit;
					we = !hit;
				end
				REQ_TICK_C: begin
					we = 1'b1;
					if (rdata.life != '0) wdata.life = rdata.life - 1'b1;
				end
				default: begin
					keep = (rdata.life != '0);
					we = keep;
				end
			endcase
		end else if (state_q == ST_DONE && req_q == REQ_ADD_C && !found_q && used_q < FULL) begin
			we = 1'b1;
			waddr = used_q[AW-1:0];
			wdata.id = id_q;
			wdata.kind = kind_q;
			wdata.txn = txn_q;
			wdata.life = life_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			rv_q <= 1'b0;
			strobe <= 1'b0;
			half_q <= 1'b0;
			rep_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q <= req_type;
						id_q <= mobile_id;
						kind_q <= chan_kind;
						txn_q <= txn_number;
						life_q <= LIFE_BITS'(lifetime);
						found_q <= 1'b0;
						ftxn_q <= '0;
						rd_q <= '0;
						wr_q <= '0;
						rv_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rv_q) begin
						if (hit) begin
							found_q <= 1'b1;
							ftxn_q <= rdata.txn;
						end
						if (keep) wr_q <= wr_q + 1'b1;
					end
					if (rd_q < used_q) begin
						rd_q <= rd_q + 1'b1;
						rv_q <= 1'b1;
					end else begin
						rv_q <= 1'b0;
						if (!rv_q) state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					case (req_q)
						REQ_ADD_C: begin
							if (!found_q && used_q < FULL) used_q <= used_q + 1'b1;
							result_kind <= pte_pkg::RES_ADD;
							was_renewed <= found_q;
							table_full <= !found_q && used_q >= FULL;
							found_txn <= '0;
						end
						REQ_REM_C: begin
							used_q <= wr_q;
							result_kind <= pte_pkg::RES_REMOVE;
							was_renewed <= 1'b0;
							table_full <= 1'b0;
							found_txn <= ftxn_q;
						end
						default: ;
					endcase
					first_id <= '0;
					first_kind <= '0;
					second_id <= '0;
					second_kind <= '0;
					has_second <= 1'b0;
					entry_count <= '0;
					last_result <= 1'b1;
					if (req_q == REQ_ADD_C || req_q == REQ_REM_C) begin
						strobe <= 1'b1;
						state_q <= ST_IDLE;
					end else if (req_q == REQ_TICK_C) begin
						state_q <= ST_IDLE;
					end else begin
						used_q <= wr_q;
						rd_q <= '0;
						rv_q <= 1'b0;
						half_q <= 1'b0;
						rep_q <= 1'b0;
						state_q <= ST_PAGE;
					end
				end
				ST_PAGE: begin
					// read survivors; a page goes out twice, first from register then repeat
					if (rep_q) begin
						strobe <= 1'b1;
						rep_q <= 1'b0;
					end else if (rv_q) begin
						rv_q <= 1'b0;
						if (!half_q && rd_q < used_q) begin
							first_q <= rdata;
							half_q <= 1'b1;
							rd_q <= rd_q + 1'b1;
							rv_q <= 1'b1;
						end else begin
							strobe <= 1'b1;
							rep_q <= 1'b1;
							result_kind <= pte_pkg::RES_PAGE;
							found_txn <= '0;
							was_renewed <= 1'b0;
							table_full <= 1'b0;
							entry_count <= '0;
							last_result <= 1'b0;
							half_q <= 1'b0;
							if (half_q) begin
								first_id <= first_q.id;
								first_kind <= first_q.kind;
								second_id <= rdata.id;
								second_kind <= rdata.kind;
								has_second <= 1'b1;
							end else begin
								first_id <= rdata.id;
								first_kind <= rdata.kind;
								second_id <= '0;
								second_kind <= '0;
								has_second <= 1'b0;
							end
						end
					end else if (half_q) begin
						// lone last entry
						strobe <= 1'b1;
						rep_q <= 1'b1;
						result_kind <= pte_pkg::RES_PAGE;
						found_txn <= '0;
						was_renewed <= 1'b0;
						table_full <= 1'b0;
						entry_count <= '0;
						last_result <= 1'b0;
						half_q <= 1'b0;
						first_id <= first_q.id;
						first_kind <= first_q.kind;
						second_id <= '0;
						second_kind <= '0;
						has_second <= 1'b0;
					end else if (rd_q < used_q) begin
						rd_q <= rd_q + 1'b1;
						rv_q <= 1'b1;
					end else begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					strobe <= 1'b1;
					result_kind <= pte_pkg::RES_SUMMARY;
					first_id <= '0;
					first_kind <= '0;
					second_id <= '0;
					second_kind <= '0;
					has_second <= 1'b0;
					found_txn <= '0;
					was_renewed <= 1'b0;
					table_full <= 1'b0;
					entry_count <= 5'(used_q);
					last_result <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FULL) else $error("entry count beyond depth");
	a_no_strobe_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q) != ST_IDLE)
		else $error("unexpected strobe");
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> wr_q <= rd_q) else $error("write passed read");
	a_write_scope: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == ST_SCAN || state_q == ST_DONE) else $error("stray write");
endmodule
`default_nettype wire
